[rtl/light_level_effect_engine_unit_assert.svh]
// Assertion macros used by the light level effect engine checker.
`ifndef LIGHT_LEVEL_EFFECT_ENGINE_UNIT_ASSERT_SVH
`define LIGHT_LEVEL_EFFECT_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define LLEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("llee assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define LLEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("llee assertion failed");

`endif

[rtl/llee_pkg.sv]
// Shared types and constants of the light level effect engine.
`timescale 1ns / 1ps
package llee_pkg;

  typedef enum logic [1:0] {
    MODE_FADE    = 2'd0,
    MODE_GLOW    = 2'd1,
    MODE_FLICKER = 2'd2,
    MODE_STROBE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SET   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_LEVEL_A = 3'd1,
    REG_LEVEL_B = 3'd2,
    REG_TICKS_A = 3'd3,
    REG_TICKS_B = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIN  = 2'd2
  } state_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [15:0]        LEVEL_MAX = 16'hFF00;
  localparam logic signed [16:0] STEP_MAX  = 17'sh0FFFF;
  localparam logic signed [16:0] STEP_MIN  = 17'sh10000;

  localparam logic [7:0] START_HOLD_MASK = 8'd64;
  localparam logic [7:0] LOW_HOLD_MASK   = 8'd7;
  localparam logic [7:0] HIGH_HOLD_MASK  = 8'd31;

  // Restoring divider: one quotient bit per step over a 16-bit dividend.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic exec;      // apply an item that needs no divider and load the result
    logic div_load;  // latch dividend and sign for a ramp start
    logic div_step;  // one divider iteration
    logic div_done;  // commit the ramp start and load the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;  // item on the input is a ramp start with nonzero duration
    logic out_busy;  // result register full and stalled
  } dp_status_t;

endpackage

[rtl/llee_ctrl.sv]
// Controller state machine: item acceptance and divider sequencing.
`timescale 1ns / 1ps
module llee_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  llee_pkg::dp_status_t   status_i,
  output logic                   in_stall_o,
  output llee_pkg::ctrl_cmd_t    ctrl_o
);
  import llee_pkg::*;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept;
  logic                 last_step;

  assign accept    = in_valid_i && (state_q == ST_IDLE) && !status_i.out_busy;
  assign last_step = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.need_div) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = status_i.out_busy;
        ctrl_o.div_load = accept && status_i.need_div;
        ctrl_o.exec     = accept && !status_i.need_div;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
      end
      ST_FIN: begin
        ctrl_o.div_done = !status_i.out_busy;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_o.div_load) begin
      cnt_d = '0;
    end else if (ctrl_o.div_step) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/llee_dp.sv]
// Datapath: config registers, effect state, step divider, result register.
`timescale 1ns / 1ps
module llee_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  llee_pkg::ctrl_cmd_t                ctrl_i,
  output llee_pkg::dp_status_t               status_o,
  input  logic [1:0]                         cmd_i,
  input  logic [7:0]                         new_level_i,
  input  logic [7:0]                         random_byte_i,
  input  logic                               cfg_we_i,
  input  logic [llee_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [llee_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [15:0]                        level_out_o,
  output logic                               running_o,
  output logic                               rising_o
);
  import llee_pkg::*;

  // config
  mode_e       mode_q;
  logic [7:0]  level_a_q, level_b_q, ticks_a_q, ticks_b_q;

  // effect state
  logic [15:0]        level_q, level_d;
  logic signed [16:0] step_q, step_d;
  logic               ramp_q, ramp_d;
  logic [7:0]         hold_q, hold_d;
  logic               active_q, active_d;

  // divider
  logic [7:0]  rem_q;
  logic [15:0] quo_q;
  logic        neg_q;

  // result register
  logic        out_valid_q;
  logic [15:0] level_out_q;
  logic        running_q, rising_q;

  logic [15:0]        up_lvl, low_lvl;
  logic [8:0]         diff_w;
  logic               diff_neg;
  logic [7:0]         diff_mag;
  logic [8:0]         trial;
  logic               fits;
  logic signed [16:0] quo_s;
  logic signed [18:0] sum_w;
  logic [15:0]        sum_clamp;
  logic signed [16:0] step_neg;

  assign up_lvl  = {level_a_q, 8'h00};
  assign low_lvl = {level_b_q, 8'h00};

  assign diff_w   = {1'b0, level_a_q} - {1'b0, level_q[15:8]};
  assign diff_neg = diff_w[8];
  assign diff_mag = diff_neg ? 8'(-diff_w) : diff_w[7:0];

  // restoring step: remainder stays below the divisor
  assign trial = {rem_q, quo_q[15]};
  assign fits  = (trial >= {1'b0, ticks_a_q});
  assign quo_s = $signed({1'b0, quo_q});

  assign sum_w = $signed({3'b000, level_q}) + $signed({{2{step_q[16]}}, step_q});
  always_comb begin
    if (sum_w[18]) begin
      sum_clamp = '0;
    end else if (sum_w > $signed({3'b000, LEVEL_MAX})) begin
      sum_clamp = LEVEL_MAX;
    end else begin
      sum_clamp = sum_w[15:0];
    end
  end

  assign step_neg = (step_q == STEP_MIN) ? STEP_MAX : -step_q;

  assign status_o.need_div = (cmd_e'(cmd_i) == CMD_START)
                          && ((mode_q == MODE_FADE) || (mode_q == MODE_GLOW))
                          && (ticks_a_q != 8'd0);
  assign status_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    level_d  = level_q;
    step_d   = step_q;
    ramp_d   = ramp_q;
    hold_d   = hold_q;
    active_d = active_q;
    if (ctrl_i.div_done) begin
      step_d   = neg_q ? -quo_s : quo_s;
      hold_d   = '0;
      ramp_d   = (level_q <= up_lvl);
      active_d = 1'b1;
    end else if (ctrl_i.exec) begin
      case (cmd_e'(cmd_i))
        CMD_TICK: begin
          if (active_q) begin
            if (hold_q != 8'd0) begin
              hold_d = hold_q - 8'd1;
            end else begin
              case (mode_q)
                MODE_FADE: begin
                  level_d = sum_clamp;
                  if (ramp_q ? (sum_clamp >= up_lvl) : (sum_clamp <= up_lvl)) begin
                    level_d  = up_lvl;
                    active_d = 1'b0;
                  end
                end
                MODE_GLOW: begin
                  level_d = sum_clamp;
                  if (ramp_q) begin
                    if (sum_clamp >= up_lvl) begin
                      level_d = up_lvl;
                      step_d  = step_neg;
                      ramp_d  = 1'b0;
                    end
                  end else if (sum_clamp <= low_lvl) begin
                    level_d = low_lvl;
                    step_d  = step_neg;
                    ramp_d  = 1'b1;
                  end
                end
                MODE_FLICKER: begin
                  if (level_q == up_lvl) begin
                    level_d = low_lvl;
                    hold_d  = (random_byte_i & LOW_HOLD_MASK) + 8'd1;
                  end else begin
                    level_d = up_lvl;
                    hold_d  = (random_byte_i & HIGH_HOLD_MASK) + 8'd1;
                  end
                end
                MODE_STROBE: begin
                  if (level_q == up_lvl) begin
                    level_d = low_lvl;
                    hold_d  = ticks_b_q;
                  end else begin
                    level_d = up_lvl;
                    hold_d  = ticks_a_q;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        CMD_START: begin
          active_d = 1'b1;
          case (mode_q)
            MODE_FADE, MODE_GLOW: begin
              // only a zero duration gets here: saturated step
              hold_d = '0;
              step_d = diff_neg ? STEP_MIN : STEP_MAX;
              ramp_d = (level_q <= up_lvl);
            end
            MODE_FLICKER: begin
              level_d = up_lvl;
              hold_d  = (random_byte_i & START_HOLD_MASK) + 8'd1;
              step_d  = '0;
              ramp_d  = 1'b0;
            end
            MODE_STROBE: begin
              level_d = up_lvl;
              hold_d  = ticks_a_q;
              step_d  = '0;
              ramp_d  = 1'b0;
            end
            default: ;
          endcase
        end
        CMD_SET: begin
          level_d = {new_level_i, 8'h00};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_FADE;
      level_a_q <= 8'd255;
      level_b_q <= 8'd0;
      ticks_a_q <= 8'd1;
      ticks_b_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MODE:    mode_q    <= mode_e'(cfg_data_i[1:0]);
        REG_LEVEL_A: level_a_q <= cfg_data_i;
        REG_LEVEL_B: level_b_q <= cfg_data_i;
        REG_TICKS_A: ticks_a_q <= cfg_data_i;
        REG_TICKS_B: ticks_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      step_q   <= '0;
      ramp_q   <= 1'b0;
      hold_q   <= '0;
      active_q <= 1'b0;
    end else begin
      level_q  <= level_d;
      step_q   <= step_d;
      ramp_q   <= ramp_d;
      hold_q   <= hold_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      rem_q <= '0;
      quo_q <= {diff_mag, 8'h00};
      neg_q <= diff_neg;
    end else if (ctrl_i.div_step) begin
      rem_q <= fits ? 8'(trial - {1'b0, ticks_a_q}) : trial[7:0];
      quo_q <= {quo_q[14:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.exec || ctrl_i.div_done) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec || ctrl_i.div_done) begin
      level_out_q <= level_d;
      running_q   <= active_d;
      rising_q    <= ramp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_out_o = level_out_q;
  assign running_o   = running_q;
  assign rising_o    = rising_q;

endmodule

[rtl/light_level_effect_engine_unit.sv]
// Top level of the light level effect engine: controller plus datapath.
`timescale 1ns / 1ps
// Timing: tick, set-level, unknown and flicker/strobe start items land in the result
//   register at the accepting edge; a fade/glow start with a nonzero duration is
//   accepted, runs the 16 restoring-divider steps, then commits once the result is free.
// Throughput: one item per cycle, held by a dividing ramp start or a full, stalled result.
// Reset (async, active low): level, step, direction, hold and running cleared;
//   config returns to fade, upper 255, lower 0, both durations 1.
module light_level_effect_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic [7:0]                         new_level_i,
  input  logic [7:0]                         random_byte_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        level_out_o,
  output logic                               running_o,
  output logic                               rising_o,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [llee_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [llee_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import llee_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  // Controller decides when an item is taken and walks the divider;
  // everything that holds data sits in the datapath.
  llee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  // Datapath: config, effect state, step divider and the result register
  // that holds a finished item while the receiver stalls; input waits meanwhile.
  llee_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .cmd_i         (cmd_i),
    .new_level_i   (new_level_i),
    .random_byte_i (random_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .level_out_o   (level_out_o),
    .running_o     (running_o),
    .rising_o      (rising_o)
  );

endmodule

[rtl/llee_checker.sv]
// Port-level assertions for the light level effect engine, bound to the top.
`timescale 1ns / 1ps
`include "light_level_effect_engine_unit_assert.svh"
module llee_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  new_level_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [15:0] level_out_o
);
  import llee_pkg::*;

  // a stalled result holds
  `LLEE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(level_out_o))
  // no item is taken while a result is blocked
  `LLEE_ASSERT_NOW(a_in_blocked, out_valid_o && out_stall_i, in_stall_o)
  // level stays within 0..255.0
  `LLEE_ASSERT_NOW(a_level_range, out_valid_o, level_out_o <= LEVEL_MAX)
  // set level shows its value on the next cycle
  `LLEE_ASSERT_NEXT(a_set_level, in_valid_i && !in_stall_o && (cmd_i == CMD_SET), out_valid_o && (level_out_o[7:0] == 8'h00) && (level_out_o[15:8] == $past(new_level_i)))

endmodule

bind light_level_effect_engine_unit llee_checker u_llee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .new_level_i (new_level_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .level_out_o (level_out_o)
);

[tb/tb_light_level_effect_engine_unit.sv]
// Testbench for the light level effect engine: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb_light_level_effect_engine_unit;
  import llee_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;   // not decoded by the block
  localparam int STEP_HI         = 65535;
  localparam int STEP_LO         = -65536;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 24;        // room for a ramp start to finish
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int PRINT_CAP       = 200;

  typedef struct packed {
    logic [15:0] level;
    logic        running;
    logic        rising;
  } light_state_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd_code    = CMD_TICK;
  logic [7:0]  new_level   = '0;
  logic [7:0]  random_byte = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [15:0] level_out;
  logic        running;
  logic        rising;
  logic        cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predicted light channel
  logic [15:0] light_level;
  int          step_size;
  logic        ramp_up;
  logic [7:0]  hold_count;
  logic        effect_on;

  // shadow of the register file
  mode_e      cfg_mode;
  logic [7:0] cfg_level_a;
  logic [7:0] cfg_level_b;
  logic [7:0] cfg_ticks_a;
  logic [7:0] cfg_ticks_b;

  light_state_t expected_light_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_max        = 0;   // 0: sender never idles
  int stall_pct      = 0;   // 0: receiver never stalls
  int stall_run      = 0;
  logic stall_on     = 1'b0;

  light_level_effect_engine_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd_code),
    .new_level_i   (new_level),
    .random_byte_i (random_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .level_out_o   (level_out),
    .running_o     (running),
    .rising_o      (rising),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic logic [15:0] add_step(input logic [15:0] lvl, input int step);
    int sum;
    sum = int'(lvl) + step;
    if (sum < 0) return '0;
    if (sum > int'(LEVEL_MAX)) return LEVEL_MAX;
    return sum[15:0];
  endfunction

  // Advance the predicted channel by one accepted item and queue the result.
  task automatic apply_item(input logic [1:0] cmd, input logic [7:0] lvl, input logic [7:0] rnd);
    logic [15:0] upper;
    logic [15:0] lower;
    int          diff;
    upper = {cfg_level_a, 8'h00};
    lower = {cfg_level_b, 8'h00};
    case (cmd)
      CMD_START: begin
        effect_on = 1'b1;
        if (cfg_mode == MODE_FADE || cfg_mode == MODE_GLOW) begin
          diff       = int'(cfg_level_a) - int'(light_level[15:8]);
          hold_count = '0;
          if (cfg_ticks_a == 0) begin
            step_size = (diff >= 0) ? STEP_HI : STEP_LO;   // zero duration saturates
          end else begin
            step_size = (diff * 256) / int'(cfg_ticks_a);  // truncates toward zero
          end
          ramp_up = (light_level <= upper);
        end else begin
          light_level = upper;
          step_size   = 0;
          ramp_up     = 1'b0;
          hold_count  = (cfg_mode == MODE_FLICKER) ? (rnd & START_HOLD_MASK) + 8'd1
                                                   : cfg_ticks_a;
        end
      end
      CMD_SET: begin
        light_level = {lvl, 8'h00};
      end
      CMD_TICK: begin
        if (effect_on) begin
          if (hold_count != 0) begin
            hold_count = hold_count - 8'd1;
          end else begin
            case (cfg_mode)
              MODE_FADE: begin
                light_level = add_step(light_level, step_size);
                if (ramp_up ? (light_level >= upper) : (light_level <= upper)) begin
                  light_level = upper;
                  effect_on   = 1'b0;
                end
              end
              MODE_GLOW: begin
                light_level = add_step(light_level, step_size);
                if (ramp_up) begin
                  if (light_level >= upper) begin
                    light_level = upper;
                    step_size   = (step_size <= STEP_LO) ? STEP_HI : -step_size;
                    ramp_up     = 1'b0;
                  end
                end else if (light_level <= lower) begin
                  light_level = lower;
                  step_size   = (step_size <= STEP_LO) ? STEP_HI : -step_size;
                  ramp_up     = 1'b1;
                end
              end
              MODE_FLICKER: begin
                if (light_level == upper) begin
                  light_level = lower;
                  hold_count  = (rnd & LOW_HOLD_MASK) + 8'd1;
                end else begin
                  light_level = upper;
                  hold_count  = (rnd & HIGH_HOLD_MASK) + 8'd1;
                end
              end
              default: begin
                if (light_level == upper) begin
                  light_level = lower;
                  hold_count  = cfg_ticks_b;
                end else begin
                  light_level = upper;
                  hold_count  = cfg_ticks_a;
                end
              end
            endcase
          end
        end
      end
      default: ;  // unknown command leaves the state alone
    endcase
    expected_light_q.push_back('{level: light_level, running: effect_on, rising: ramp_up});
  endtask

  // Offer one item, wait for it to be taken, then maybe open a gap.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] lvl, input logic [7:0] rnd);
    in_valid    <= 1'b1;
    cmd_code    <= cmd;
    new_level   <= lvl;
    random_byte <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(cmd, lvl, rnd);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering items and let every queued result come out.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_light_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_MODE:    cfg_mode    = mode_e'(data[1:0]);
      REG_LEVEL_A: cfg_level_a = data;
      REG_LEVEL_B: cfg_level_b = data;
      REG_TICKS_A: cfg_ticks_a = data;
      REG_TICKS_B: cfg_ticks_b = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input mode_e mode, input logic [7:0] lvl_a, input logic [7:0] lvl_b,
                             input logic [7:0] dur_a, input logic [7:0] dur_b);
    put_reg(REG_MODE, {6'd0, mode});
    put_reg(REG_LEVEL_A, lvl_a);
    put_reg(REG_LEVEL_B, lvl_b);
    put_reg(REG_TICKS_A, dur_a);
    put_reg(REG_TICKS_B, dur_b);
    cfg_we <= 1'b0;
  endtask

  // Receiver: checks each taken result, then picks its next stall.
  always @(posedge clk) begin : result_check
    light_state_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_light_q.size() == 0) begin
          report_mismatch("result with no item waiting", int'(level_out), 0);
        end else begin
          want = expected_light_q.pop_front();
          if (level_out !== want.level)
            report_mismatch("level_out", int'(level_out), int'(want.level));
          if (running !== want.running)
            report_mismatch("running", int'(running), int'(want.running));
          if (rising !== want.rising)
            report_mismatch("rising", int'(rising), int'(want.rising));
        end
      end
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 8);
        stall_on  = ($urandom_range(0, 99) < stall_pct);
      end
      stall_run--;
      out_stall <= stall_on;
    end
  end

  // Reset defaults, idle ticks, set-level extremes and an unknown command.
  task automatic test_idle_and_set_level();
    send_item(CMD_TICK, 8'h00, 8'hFF);
    send_item(CMD_SET, 8'hFF, 8'h00);
    send_item(CMD_SET, 8'h00, 8'hFF);
    send_item(CMD_UNKNOWN, 8'hFF, 8'hFF);
    send_item(CMD_TICK, 8'hAA, 8'h55);
  endtask

  // Fade up that overshoots and clamps to the target.
  task automatic test_fade_ramp();
    wait_idle();
    load_config(MODE_FADE, 8'd200, 8'd0, 8'd3, 8'd1);
    send_item(CMD_START, 8'h00, 8'h00);
    repeat (5) send_item(CMD_TICK, 8'h00, 8'h00);
  endtask

  // Zero duration glow: clamps at both ends and the negative limit step negation.
  task automatic test_glow_saturation();
    wait_idle();
    load_config(MODE_GLOW, 8'd10, 8'd250, 8'd0, 8'd0);
    send_item(CMD_SET, 8'hFF, 8'h00);
    send_item(CMD_START, 8'h00, 8'h00);
    repeat (3) send_item(CMD_TICK, 8'h00, 8'h00);
    send_item(CMD_SET, 8'h80, 8'h00);   // load while running
    send_item(CMD_TICK, 8'h00, 8'h00);
  endtask

  // Flicker start with both start hold values, then strobe with zero and full holds.
  task automatic test_flicker_strobe();
    wait_idle();
    load_config(MODE_FLICKER, 8'd255, 8'd0, 8'd0, 8'd255);
    send_item(CMD_START, 8'h00, 8'hBF);
    send_item(CMD_TICK, 8'h00, 8'h00);
    send_item(CMD_TICK, 8'h00, 8'h47);
    send_item(CMD_START, 8'h00, 8'h40);
    wait_idle();
    load_config(MODE_STROBE, 8'd255, 8'd0, 8'd0, 8'd255);
    send_item(CMD_START, 8'h00, 8'h00);
    repeat (3) send_item(CMD_TICK, 8'h00, 8'h00);
  endtask

  // Random phases: a start followed by mostly ticks, some restarts, loads and noise.
  task automatic test_random_effects();
    int         sent;
    int         pick;
    logic [1:0] cmd;
    logic [7:0] dur_a;
    logic [7:0] dur_b;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(10, 60);
      dur_a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      dur_b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      if (phase == 0) begin
        load_config(MODE_FADE, 8'd0, 8'd255, 8'd0, 8'd0);
      end else if (phase == 1) begin
        load_config(MODE_GLOW, 8'd255, 8'd0, 8'd255, 8'd255);
      end else begin
        load_config(mode_e'(phase % 4), 8'($urandom), 8'($urandom), dur_a, dur_b);
      end
      send_item(CMD_START, 8'($urandom), 8'($urandom));
      sent = 1;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(CMD_UNKNOWN, 8'($urandom), 8'($urandom));
        end else begin
          if (pick < 12) cmd = CMD_START;
          else if (pick < 18) cmd = CMD_SET;
          else cmd = CMD_TICK;
          send_item(cmd, 8'($urandom), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    cfg_mode    = MODE_FADE;
    cfg_level_a = 8'd255;
    cfg_level_b = 8'd0;
    cfg_ticks_a = 8'd1;
    cfg_ticks_b = 8'd1;
    light_level = '0;
    step_size   = 0;
    ramp_up     = 1'b0;
    hold_count  = '0;
    effect_on   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_set_level();
    test_fade_ramp();
    test_glow_saturation();
    test_flicker_strobe();
    test_random_effects();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
